/* hdl/randomized_prim_maze_carver_assert.svh */
// Assertion macros for the maze carver.
`ifndef RANDOMIZED_PRIM_MAZE_CARVER_ASSERT_SVH
`define RANDOMIZED_PRIM_MAZE_CARVER_ASSERT_SVH
`ifndef SYNTHESIS
`define RPMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RPMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RPMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/rpmc_pkg.sv */
`timescale 1ns / 1ps
package rpmc_pkg;
    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_EAST  = 2'd2;
    localparam logic [1:0] SIDE_WEST  = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,    // visited map sweep
        ST_IDLE,
        ST_MOD,      // serial remainder
        ST_RDWALL,   // wall list read issued
        ST_RDV1,     // first cell visited read
        ST_RDV2,     // second cell visited read
        ST_DECIDE,
        ST_PUSH,     // append up to four walls
        ST_SHIFT_RD, // order-preserving erase
        ST_SHIFT_WR,
        ST_OUT
    } state_t;
endpackage

/* hdl/randomized_prim_maze_carver.sv */
`timescale 1ns / 1ps
// Randomized Prim maze carver. Each input transfer yields exactly one result transfer.
// A start item clears the visited map with a sweep (one cell per cycle) and then seeds
// cell (0,0); the same sweep runs once after reset, during which no item is taken. A step
// runs a bit-serial remainder, three memory reads and a decide state; when a passage is
// carved it then walks four append slots. The step then erases the chosen entry, moving
// each entry above it through the single-port wall memory one at a time. A step on an
// empty list goes straight to the output. Results sit in an output register and no new
// item is taken while it is full.
`include "randomized_prim_maze_carver_assert.svh"
module randomized_prim_maze_carver #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int LIST_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [30:0] random_value
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // first_row, first_col, second_row, second_col, opened_side
    output logic [1:0]  m_tuser,  // carved, finished
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NCELL = MAX_ROWS * MAX_COLS;
    localparam int AB = $clog2(NCELL);
    localparam int LB = $clog2(LIST_DEPTH);
    localparam int WB = RB + CB + 2;

    rpmc_pkg::state_t state_reg, state_next;
    logic [5:0] rows_reg, cols_reg;
    logic [LB:0] count_reg;
    logic [AB-1:0] clr_reg;
    logic [30:0] rnd_reg;
    logic [LB:0] rem_reg;
    logic [4:0] bit_reg;
    logic [LB:0] idx_reg;
    logic [RB-1:0] wr_reg, nr_reg, pr_reg;
    logic [CB-1:0] wc_reg, nc_reg, pc_reg;
    logic [1:0] ws_reg;
    logic v1_reg;
    logic [2:0] push_reg;
    logic kind_reg, carved_reg;
    logic out_valid_reg;
    logic [23:0] out_data_reg;
    logic [1:0] out_user_reg;

    logic vmem [NCELL];
    logic [WB-1:0] wmem [LIST_DEPTH];
    logic vrd_reg;
    logic [WB-1:0] wrd_reg;
    logic v_we, v_wd;
    logic [AB-1:0] v_addr;
    logic w_we;
    logic [LB-1:0] w_addr;
    logic [WB-1:0] w_wd;

    always_ff @(posedge aclk) begin
        if (v_we) vmem[v_addr] <= v_wd;
        vrd_reg <= vmem[v_addr];
    end
    always_ff @(posedge aclk) begin
        if (w_we) wmem[w_addr] <= w_wd;
        wrd_reg <= wmem[w_addr];
    end

    // clamped grid size
    logic [8:0] rows_u, cols_u;
    always_comb begin
        rows_u = (rows_reg == 6'd0) ? 9'd1 :
                 ({3'd0, rows_reg} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {3'd0, rows_reg};
        cols_u = (cols_reg == 6'd0) ? 9'd1 :
                 ({3'd0, cols_reg} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {3'd0, cols_reg};
    end

    // serial remainder step
    logic [LB+1:0] rem_try;
    assign rem_try = {rem_reg, rnd_reg[bit_reg]} - {1'b0, count_reg};

    // next append from the push cursor (order: south, north, west, east)
    logic push_ok;
    logic [1:0] push_side;
    always_comb begin
        push_ok = 1'b0;
        push_side = rpmc_pkg::SIDE_SOUTH;
        unique case (push_reg)
            3'd0: begin push_ok = (pr_reg != '0); push_side = rpmc_pkg::SIDE_SOUTH; end
            3'd1: begin
                push_ok = (9'(pr_reg) + 9'd1 < rows_u); push_side = rpmc_pkg::SIDE_NORTH;
            end
            3'd2: begin push_ok = (pc_reg != '0); push_side = rpmc_pkg::SIDE_WEST; end
            3'd3: begin
                push_ok = (9'(pc_reg) + 9'd1 < cols_u); push_side = rpmc_pkg::SIDE_EAST;
            end
            default: push_ok = 1'b0;
        endcase
    end
    logic full;
    assign full = (count_reg >= (LB+1)'(LIST_DEPTH));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpmc_pkg::ST_CLEAR:
                if (clr_reg == AB'(NCELL - 1))
                    state_next = kind_reg ? rpmc_pkg::ST_IDLE : rpmc_pkg::ST_PUSH;
            rpmc_pkg::ST_IDLE:
                if (s_tvalid && !out_valid_reg)
                    state_next = s_tuser ? ((count_reg == '0) ? rpmc_pkg::ST_OUT
                                                             : rpmc_pkg::ST_MOD)
                                         : rpmc_pkg::ST_CLEAR;
            rpmc_pkg::ST_MOD:    if (bit_reg == 5'd0) state_next = rpmc_pkg::ST_RDWALL;
            rpmc_pkg::ST_RDWALL: state_next = rpmc_pkg::ST_RDV1;
            rpmc_pkg::ST_RDV1:   state_next = rpmc_pkg::ST_RDV2;
            rpmc_pkg::ST_RDV2:   state_next = rpmc_pkg::ST_DECIDE;
            rpmc_pkg::ST_DECIDE:
                state_next = (v1_reg != vrd_reg) ? rpmc_pkg::ST_PUSH : rpmc_pkg::ST_SHIFT_RD;
            rpmc_pkg::ST_PUSH:
                if (push_reg == 3'd3)
                    state_next = kind_reg ? rpmc_pkg::ST_SHIFT_RD : rpmc_pkg::ST_OUT;
            rpmc_pkg::ST_SHIFT_RD:
                state_next = (idx_reg + 1'b1 >= count_reg) ? rpmc_pkg::ST_OUT
                                                           : rpmc_pkg::ST_SHIFT_WR;
            rpmc_pkg::ST_SHIFT_WR: state_next = rpmc_pkg::ST_SHIFT_RD;
            rpmc_pkg::ST_OUT:      state_next = rpmc_pkg::ST_IDLE;
            default:               state_next = rpmc_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        v_we = 1'b0; v_wd = 1'b0; v_addr = '0;
        w_we = 1'b0; w_wd = '0; w_addr = '0;
        unique case (state_reg)
            rpmc_pkg::ST_CLEAR: begin v_we = 1'b1; v_addr = clr_reg; end
            rpmc_pkg::ST_MOD: w_addr = rem_try[LB+1] ? LB'(rem_reg) : LB'(rem_try);
            // chosen entry, data valid in the next state
            rpmc_pkg::ST_RDWALL: w_addr = LB'(idx_reg);
            rpmc_pkg::ST_RDV1: begin
                v_addr = AB'(32'(wrd_reg[WB-1 -: RB]) * MAX_COLS + 32'(wrd_reg[2 +: CB]));
            end
            rpmc_pkg::ST_RDV2: v_addr = AB'(32'(nr_reg) * MAX_COLS + 32'(nc_reg));
            rpmc_pkg::ST_PUSH: begin
                if (push_reg == 3'd0) begin
                    v_we = 1'b1; v_wd = 1'b1;
                    v_addr = AB'(32'(pr_reg) * MAX_COLS + 32'(pc_reg));
                end
                w_we = push_ok && !full && (push_reg != 3'd4);
                w_addr = LB'(count_reg);
                w_wd = {pr_reg, pc_reg, push_side};
            end
            rpmc_pkg::ST_SHIFT_RD: w_addr = LB'(idx_reg + 1'b1);
            rpmc_pkg::ST_SHIFT_WR: begin w_we = 1'b1; w_addr = LB'(idx_reg); w_wd = wrd_reg; end
            default: ;
        endcase
    end

    // neighbour of the fetched wall
    logic [RB-1:0] f_r, f_nr;
    logic [CB-1:0] f_c, f_nc;
    logic [1:0] f_s;
    always_comb begin
        f_r = wrd_reg[WB-1 -: RB];
        f_c = wrd_reg[2 +: CB];
        f_s = wrd_reg[1:0];
        f_nr = f_r; f_nc = f_c;
        unique case (f_s)
            rpmc_pkg::SIDE_NORTH: f_nr = f_r + 1'b1;
            rpmc_pkg::SIDE_SOUTH: f_nr = f_r - 1'b1;
            rpmc_pkg::SIDE_EAST:  f_nc = f_c + 1'b1;
            default:              f_nc = f_c - 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpmc_pkg::ST_CLEAR;
            rows_reg <= 6'd32; cols_reg <= 6'd32;
            count_reg <= '0; clr_reg <= '0;
            kind_reg <= 1'b1; out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rpmc_pkg::CFG_ROWS) rows_reg <= cfg_data;
                else cols_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                rpmc_pkg::ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    pr_reg <= '0; pc_reg <= '0; push_reg <= 3'd0; count_reg <= '0;
                    carved_reg <= 1'b0;
                end
                rpmc_pkg::ST_IDLE: if (s_tvalid && !out_valid_reg) begin
                    kind_reg <= s_tuser; rnd_reg <= s_tdata[30:0];
                    rem_reg <= '0; bit_reg <= 5'd30; carved_reg <= 1'b0;
                    clr_reg <= '0;
                end
                rpmc_pkg::ST_MOD: begin
                    rem_reg <= rem_try[LB+1] ? {rem_reg[LB-1:0], rnd_reg[bit_reg]}
                                             : rem_try[LB:0];
                    bit_reg <= bit_reg - 1'b1;
                    idx_reg <= rem_try[LB+1] ? {rem_reg[LB-1:0], rnd_reg[bit_reg]}
                                             : rem_try[LB:0];
                end
                rpmc_pkg::ST_RDV1: begin
                    wr_reg <= f_r; wc_reg <= f_c; ws_reg <= f_s;
                    nr_reg <= f_nr; nc_reg <= f_nc;
                end
                rpmc_pkg::ST_RDV2: v1_reg <= vrd_reg;
                rpmc_pkg::ST_DECIDE: if (v1_reg != vrd_reg) begin
                    carved_reg <= 1'b1; push_reg <= 3'd0;
                    pr_reg <= v1_reg ? nr_reg : wr_reg;
                    pc_reg <= v1_reg ? nc_reg : wc_reg;
                end
                rpmc_pkg::ST_PUSH: begin
                    push_reg <= push_reg + 1'b1;
                    if (push_ok && !full) count_reg <= count_reg + 1'b1;
                end
                rpmc_pkg::ST_SHIFT_RD:
                    if (idx_reg + 1'b1 >= count_reg) count_reg <= count_reg - 1'b1;
                rpmc_pkg::ST_SHIFT_WR: idx_reg <= idx_reg + 1'b1;
                rpmc_pkg::ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_user_reg <= {count_reg == '0, carved_reg};
                    out_data_reg <= carved_reg ?
                        {2'b0, ws_reg, 5'(nc_reg), 5'(nr_reg), 5'(wc_reg), 5'(wr_reg)} : '0;
                end
                default: ;
            endcase
        end
    end

    assign s_tready  = (state_reg == rpmc_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    `RPMC_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `RPMC_ASSERT_IMPL(a_count_cap, aclk, aresetn, 1'b1, count_reg <= (LB+1)'(LIST_DEPTH))
    `RPMC_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_tvalid, !s_tready)
endmodule
